[rtl/i2c_master_10bit_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// i2c_master_10bit_sequencer_defines.svh
// Assertion macros used by the sequencer's checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_10BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_10BIT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, silenced while reset is applied.
`define I2C10_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication, silenced while reset is applied.
`define I2C10_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication that also holds across reset.
`define I2C10_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sequencer reset check failed");

`endif

[rtl/i2c10_pkg.sv]
// ----------------------------------------------------------------------------
// i2c10_pkg
// Command codes, result type and header helper for the 10-bit I2C sequencer.
// ----------------------------------------------------------------------------
package i2c10_pkg;

  // Bus event codes; codes six and seven have no meaning
  typedef enum logic [2:0] {
    CMD_BEGIN_WR = 3'd0,
    CMD_BEGIN_RD = 3'd1,
    CMD_START_DONE = 3'd2,
    CMD_ACK = 3'd3,
    CMD_NACK = 3'd4,
    CMD_TIMEOUT = 3'd5
  } cmd_t;

  // Upper five bits of a 10-bit address header (0x1E << 2, shifted once more)
  localparam logic [4:0] HDR_PREFIX = 5'b11110;
  localparam logic       RW_WRITE   = 1'b0;
  localparam logic       RW_READ    = 1'b1;
  localparam logic [1:0] RD_LIMIT   = 2'd2;
  localparam logic [1:0] WR_LIMIT   = 2'd3;
  localparam logic [1:0] NO_ENTRY   = 2'd3;

  // One result beat
  typedef struct packed {
    logic       load_tx;
    logic [7:0] tx_value;
    logic       send_start;
    logic       send_stop;
    logic       trigger;
    logic       done_res;
    logic       aborted;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       unexpected;
  } result_t;

  // Build the first header byte from the address high bits and R/W
  function automatic logic [7:0] header_byte(input logic [1:0] addr_hi, input logic rw);
    return {HDR_PREFIX, addr_hi, rw};
  endfunction

endpackage

[rtl/i2c10_in_if.sv]
// ----------------------------------------------------------------------------
// i2c10_in_if
// Bus event channel: valid/ready handshake with the event payload.
// ----------------------------------------------------------------------------
interface i2c10_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [9:0] slave_address;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic [7:0] bus_data;

  modport source (
    output valid, command, slave_address, first_byte, second_byte, third_byte, bus_data,
    input  ready
  );
  modport sink (
    input  valid, command, slave_address, first_byte, second_byte, third_byte, bus_data,
    output ready
  );
endinterface

[rtl/i2c10_out_if.sv]
// ----------------------------------------------------------------------------
// i2c10_out_if
// Result channel: valid/ready handshake with the sequencer's answer.
// ----------------------------------------------------------------------------
interface i2c10_out_if;
  logic       valid;
  logic       ready;
  logic       load_tx;
  logic [7:0] tx_value;
  logic       send_start;
  logic       send_stop;
  logic       trigger;
  logic       done_res;
  logic       aborted;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       unexpected;

  modport source (
    output valid, load_tx, tx_value, send_start, send_stop, trigger, done_res, aborted,
           read_byte, read_valid, unexpected,
    input  ready
  );
  modport sink (
    input  valid, load_tx, tx_value, send_start, send_stop, trigger, done_res, aborted,
           read_byte, read_valid, unexpected,
    output ready
  );
endinterface

[rtl/i2c_master_10bit_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_10bit_sequencer
// Turns I2C bus events into transmit loads and START/STOP requests for a
// transaction with a 10-bit slave address, one result beat per event beat.
// ----------------------------------------------------------------------------
//  channel   direction  beat carries
//  in_ch     sink       bus event, address and payload operands
//  out_ch    source     tx load, bus condition requests and status flags
//
//  One event beat per cycle sustained while out_ch.ready is high; beats
//  pass the input register, then the result register. Sequencer state
//  and result register advance together; a stalled result holds the item
//  in the input register; in_ch.ready drops only with both stages full.
//  Reset clears phase, mode, byte count, address and both valid flags.
// ----------------------------------------------------------------------------
module i2c_master_10bit_sequencer
  import i2c10_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  i2c10_in_if.sink    in_ch,
  i2c10_out_if.source out_ch
);

  typedef enum logic [2:0] {
    PH_START, PH_HDR_WR, PH_LOW_ADDR, PH_DATA, PH_RESTART, PH_HDR_RD, PH_READ, PH_STOP
  } phase_t;

  // Input stage
  logic       in_v_r;
  logic [2:0] cmd_r;
  logic [9:0] addr_in_r;
  logic [7:0] b0_r, b1_r, b2_r, bus_r;

  // Sequencer state
  phase_t     phase_r, phase_nxt;
  logic       rd_mode_r, rd_mode_nxt;
  logic [1:0] sent_r, sent_nxt;
  logic [9:0] taddr_r, taddr_nxt;
  logic [7:0] pay_r [3];

  // Result stage
  logic       out_v_r;
  result_t    res_r, res_nxt;

  logic       advance;
  logic       in_fire;
  logic [7:0] pay_val;

  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Current payload byte, zero past the last entry
  assign pay_val = (sent_r != NO_ENTRY) ? pay_r[sent_r] : 8'h00;

  // Decide the answer and the next state for the held event
  always_comb begin
    res_nxt     = '0;
    phase_nxt   = phase_r;
    rd_mode_nxt = rd_mode_r;
    sent_nxt    = sent_r;
    taddr_nxt   = taddr_r;
    unique case (cmd_r)
      CMD_BEGIN_WR, CMD_BEGIN_RD: begin
        taddr_nxt          = addr_in_r;
        rd_mode_nxt        = (cmd_r == CMD_BEGIN_RD);
        sent_nxt           = 2'd0;
        phase_nxt          = PH_START;
        res_nxt.send_start = 1'b1;
      end
      CMD_START_DONE: begin
        res_nxt.trigger = 1'b1;
        if (!rd_mode_r || phase_r == PH_START) begin
          res_nxt.load_tx  = 1'b1;
          res_nxt.tx_value = header_byte(taddr_r[9:8], RW_WRITE);
          phase_nxt        = PH_HDR_WR;
        end else if (phase_r == PH_RESTART) begin
          res_nxt.load_tx  = 1'b1;
          res_nxt.tx_value = header_byte(taddr_r[9:8], RW_READ);
          phase_nxt        = PH_HDR_RD;
        end else begin
          res_nxt.unexpected = 1'b1;
        end
      end
      CMD_ACK: begin
        priority if (phase_r == PH_HDR_WR) begin
          res_nxt.load_tx  = 1'b1;
          res_nxt.tx_value = taddr_r[7:0];
          res_nxt.trigger  = 1'b1;
          phase_nxt        = PH_LOW_ADDR;
        end else if (phase_r == PH_LOW_ADDR) begin
          res_nxt.load_tx  = 1'b1;
          res_nxt.tx_value = pay_val;
          res_nxt.trigger  = 1'b1;
          sent_nxt         = sent_r + 2'd1;
          phase_nxt        = PH_DATA;
        end else if (phase_r == PH_DATA) begin
          res_nxt.trigger = 1'b1;
          if (sent_r != (rd_mode_r ? RD_LIMIT : WR_LIMIT)) begin
            res_nxt.load_tx  = 1'b1;
            res_nxt.tx_value = pay_val;
            sent_nxt         = sent_r + 2'd1;
          end else if (rd_mode_r) begin
            res_nxt.send_start = 1'b1;
            phase_nxt          = PH_RESTART;
          end else begin
            res_nxt.send_stop = 1'b1;
            res_nxt.done_res  = 1'b1;
            phase_nxt         = PH_STOP;
          end
        end else if (phase_r == PH_HDR_RD && rd_mode_r) begin
          res_nxt.trigger = 1'b1;
          phase_nxt       = PH_READ;
        end else begin
          res_nxt.unexpected = 1'b1;
        end
      end
      CMD_NACK: begin
        priority if (phase_r == PH_HDR_WR) begin
          res_nxt.send_start = 1'b1;
          res_nxt.trigger    = 1'b1;
          phase_nxt          = PH_START;
        end else if (phase_r == PH_LOW_ADDR || (phase_r == PH_DATA && !rd_mode_r)) begin
          res_nxt.send_stop = 1'b1;
          res_nxt.trigger   = 1'b1;
          res_nxt.aborted   = 1'b1;
          phase_nxt         = PH_STOP;
        end else if (phase_r == PH_READ && rd_mode_r) begin
          res_nxt.read_byte  = bus_r;
          res_nxt.read_valid = 1'b1;
          res_nxt.done_res   = 1'b1;
          res_nxt.send_stop  = 1'b1;
          res_nxt.trigger    = 1'b1;
          phase_nxt          = PH_STOP;
        end else begin
          res_nxt.unexpected = 1'b1;
        end
      end
      CMD_TIMEOUT: begin
        res_nxt = '0;
      end
      default: begin
        res_nxt.unexpected = 1'b1;
      end
    endcase
  end

  // Hold state, input stage and result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      phase_r   <= PH_START;
      rd_mode_r <= 1'b0;
      sent_r    <= 2'd0;
      taddr_r   <= 10'd0;
    end else begin
      // Capture an accepted event beat
      if (in_fire) begin
        cmd_r     <= in_ch.command;
        addr_in_r <= in_ch.slave_address;
        b0_r      <= in_ch.first_byte;
        b1_r      <= in_ch.second_byte;
        b2_r      <= in_ch.third_byte;
        bus_r     <= in_ch.bus_data;
      end
      if (in_fire) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      // Advance the sequencer and load the result
      if (advance) begin
        phase_r   <= phase_nxt;
        rd_mode_r <= rd_mode_nxt;
        sent_r    <= sent_nxt;
        taddr_r   <= taddr_nxt;
        res_r     <= res_nxt;
        if (cmd_r == CMD_BEGIN_WR || cmd_r == CMD_BEGIN_RD) begin
          pay_r[0] <= b0_r;
          pay_r[1] <= b1_r;
        end
        if (cmd_r == CMD_BEGIN_WR) begin
          pay_r[2] <= b2_r;
        end
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Drive the result channel
  assign out_ch.valid      = out_v_r;
  assign out_ch.load_tx    = res_r.load_tx;
  assign out_ch.tx_value   = res_r.tx_value;
  assign out_ch.send_start = res_r.send_start;
  assign out_ch.send_stop  = res_r.send_stop;
  assign out_ch.trigger    = res_r.trigger;
  assign out_ch.done_res   = res_r.done_res;
  assign out_ch.aborted    = res_r.aborted;
  assign out_ch.read_byte  = res_r.read_byte;
  assign out_ch.read_valid = res_r.read_valid;
  assign out_ch.unexpected = res_r.unexpected;

endmodule

[rtl/i2c10_checker.sv]
// ----------------------------------------------------------------------------
// i2c10_checker
// Port-level checks on the sequencer's result channel, bound to the top.
// ----------------------------------------------------------------------------
`include "i2c_master_10bit_sequencer_defines.svh"

module i2c10_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       load_tx,
  input logic [7:0] tx_value,
  input logic       send_stop,
  input logic       done_res,
  input logic       aborted,
  input logic [7:0] read_byte,
  input logic       read_valid
);

  // A stalled result beat stays offered
  `I2C10_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  // A read byte only comes with a completed, stopped transaction
  `I2C10_ASSERT_IMP(a_read_done, out_valid && read_valid, done_res && send_stop && !load_tx)
  // An abort always stops the bus and never claims completion
  `I2C10_ASSERT_IMP(a_abort_stop, out_valid && aborted, send_stop && !done_res && !read_valid)
  // Unused byte fields read as zero
  `I2C10_ASSERT_IMP(a_zero_bytes, out_valid && !load_tx && !read_valid,
                    tx_value == 8'h00 && read_byte == 8'h00)
  // No result is offered right after reset
  `I2C10_ASSERT_RST(a_reset_idle, !rst_n, !out_valid)

endmodule

bind i2c_master_10bit_sequencer i2c10_checker u_i2c10_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .load_tx    (out_ch.load_tx),
  .tx_value   (out_ch.tx_value),
  .send_stop  (out_ch.send_stop),
  .done_res   (out_ch.done_res),
  .aborted    (out_ch.aborted),
  .read_byte  (out_ch.read_byte),
  .read_valid (out_ch.read_valid)
);
